// ----- design/pipt_pkg.sv -----
package pipt_pkg;

	// outcome of one edge test against the query point
	typedef struct packed {
		logic straddle;
		logic left;
	} pipt_cross_t;

endpackage

// ----- design/pipt_edge.sv -----
module pipt_edge
	import pipt_pkg::*;
#(
	parameter int COORD_BITS = 32
) (
	input  logic signed [COORD_BITS-1:0] xa,
	input  logic signed [COORD_BITS-1:0] za,
	input  logic signed [COORD_BITS-1:0] xb,
	input  logic signed [COORD_BITS-1:0] zb,
	input  logic signed [COORD_BITS-1:0] qx,
	input  logic signed [COORD_BITS-1:0] qz,
	output pipt_cross_t                  crossing
);

	localparam int W = COORD_BITS + 1;

	logic signed [W-1:0]   xa_w, za_w, xb_w, zb_w, qx_w, qz_w;
	logic signed [W-1:0]   dz, dqx, dx, dqz;
	logic signed [2*W-1:0] lhs, rhs;

	assign xa_w = {xa[COORD_BITS-1], xa};
	assign za_w = {za[COORD_BITS-1], za};
	assign xb_w = {xb[COORD_BITS-1], xb};
	assign zb_w = {zb[COORD_BITS-1], zb};
	assign qx_w = {qx[COORD_BITS-1], qx};
	assign qz_w = {qz[COORD_BITS-1], qz};

	assign dz  = zb_w - za_w;
	assign dqx = qx_w - xa_w;
	assign dx  = xb_w - xa_w;
	assign dqz = qz_w - za_w;

	// crossing x compared against query x without a divide
	assign lhs = dqx * dz;
	assign rhs = dx * dqz;

	assign crossing.straddle = (za > qz) != (zb > qz);
	assign crossing.left     = dz[W-1] ? (lhs > rhs) : (lhs < rhs);

endmodule

// ----- design/point_in_polygon_test_top.sv -----
// point-in-polygon crossing-number test on the x/z ground plane
//
// input channel (vertex_valid/vertex_ready): one polygon vertex per
// transaction, signed Q16.16 coordinates; point_x/point_z are taken only
// with the first vertex of a polygon, last_vertex closes the polygon
// output channel (result_valid/result_ready): one inside_res transaction
// per polygon, given after its last vertex (even-odd rule)
// throughput: one vertex per cycle unless a last vertex stalls; each vertex is tested against the
// previous vertex (and against the first vertex on a last vertex) by the edge units
// u_edge_prev and u_edge_close, working in parallel while it sits in its input register
// result: a last vertex in the input register sets the registered result_valid
// reset: clears the pipeline, parity and the in-polygon flag, so the next
// vertex starts a new polygon
// stall: while a result waits, non-last vertices keep flowing; a further
// last vertex holds in the input register and vertex_ready drops until
// the waiting result is taken
module point_in_polygon_test_top
	import pipt_pkg::*;
#(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vertex_valid,
	output logic                         vertex_ready,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_z,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_z,
	input  logic                         last_vertex,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic                         inside_res
);

	logic                         valid_s1, last_s1;
	logic signed [COORD_BITS-1:0] vx_s1, vz_s1, px_s1, pz_s1;

	logic signed [COORD_BITS-1:0] first_x_q, first_z_q, prev_x_q, prev_z_q;
	logic signed [COORD_BITS-1:0] query_x_q, query_z_q;
	logic                         parity_q, in_poly_q;
	logic                         result_valid_q, inside_q;

	logic signed [COORD_BITS-1:0] qx, qz, fx, fz;
	pipt_cross_t                  cr_prev, cr_close;
	logic                         out_free, advance, parity_next;

	assign out_free     = !result_valid_q || result_ready;
	assign advance      = valid_s1 && (!last_s1 || out_free);
	assign vertex_ready = !valid_s1 || advance;

	// a first vertex supplies its own query point and closing vertex
	assign qx = in_poly_q ? query_x_q : px_s1;
	assign qz = in_poly_q ? query_z_q : pz_s1;
	assign fx = in_poly_q ? first_x_q : vx_s1;
	assign fz = in_poly_q ? first_z_q : vz_s1;

	pipt_edge #(.COORD_BITS(COORD_BITS)) u_edge_prev (
		.xa(prev_x_q), .za(prev_z_q), .xb(vx_s1), .zb(vz_s1),
		.qx(qx), .qz(qz), .crossing(cr_prev)
	);

	pipt_edge #(.COORD_BITS(COORD_BITS)) u_edge_close (
		.xa(vx_s1), .za(vz_s1), .xb(fx), .zb(fz),
		.qx(qx), .qz(qz), .crossing(cr_close)
	);

	assign parity_next = (in_poly_q && (parity_q ^ (cr_prev.straddle && cr_prev.left)))
		^ (in_poly_q && last_s1 && cr_close.straddle && cr_close.left);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (vertex_ready) begin
			valid_s1 <= vertex_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (vertex_ready && vertex_valid) begin
			vx_s1   <= vertex_x;
			vz_s1   <= vertex_z;
			px_s1   <= point_x;
			pz_s1   <= point_z;
			last_s1 <= last_vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_z_q <= '0;
			prev_x_q  <= '0;
			prev_z_q  <= '0;
			query_x_q <= '0;
			query_z_q <= '0;
			parity_q  <= 1'b0;
			in_poly_q <= 1'b0;
		end else if (advance) begin
			first_x_q <= fx;
			first_z_q <= fz;
			query_x_q <= qx;
			query_z_q <= qz;
			prev_x_q  <= vx_s1;
			prev_z_q  <= vz_s1;
			parity_q  <= parity_next;
			in_poly_q <= !last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			inside_q <= parity_next;
		end
	end

	assign result_valid = result_valid_q;
	assign inside_res   = inside_q;

endmodule
